// ----- rtl/ffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared sizes, codes and types of the first-fit allocator with LRU eviction.
// ----------------------------------------------------------------------------
package ffa_pkg;

	localparam int MAX_RECORDS  = 256;
	localparam int MAX_SEGMENTS = 512;
	localparam int OFFSET_BITS  = 32;
	localparam int EVICT_LIMIT  = 10;

	localparam int SEG_IW = $clog2(MAX_SEGMENTS);       // table index
	localparam int SEG_PW = $clog2(MAX_SEGMENTS + 1);   // pointer with end mark
	localparam int REC_IW = $clog2(MAX_RECORDS);
	localparam int REC_CW = $clog2(MAX_RECORDS + 1);
	localparam int LEN_W  = OFFSET_BITS + 1;
	localparam int FRAME_W = 64;

	localparam logic [SEG_PW-1:0] SEG_END = SEG_PW'(MAX_SEGMENTS);
	localparam logic [31:0] POOL_RESET = 32'd67108864;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_TOUCH  = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OOM     = 2'd1;
	localparam logic [1:0] ST_TFULL   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] start;
		logic [LEN_W-1:0]       len;
		logic                   free;
		logic [SEG_PW-1:0]      next;
	} seg_node_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] start;
		logic [FRAME_W-1:0]     frame;
		logic                   active;
	} rec_word_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CFG,
		CMD_LOAD,
		CMD_SET_OOM,
		CMD_SET_TFULL,
		CMD_STEP,
		CMD_MARK_USED,
		CMD_SPLIT1,
		CMD_SPLIT2,
		CMD_REC_NEW,
		CMD_SCAN_INIT,
		CMD_SCAN,
		CMD_EVICT,
		CMD_FREE_HIT,
		CMD_NX_RD,
		CMD_MERGE_NX,
		CMD_MERGE_PREV,
		CMD_WALK_INIT,
		CMD_TOUCH,
		CMD_EMIT
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       size_zero;
		logic       node_fit;
		logic       node_exact;
		logic       node_end;
		logic       node_match;
		logic       tfull;
		logic       ev_over;
		logic       scan_done;
		logic       best_valid;
		logic       out_busy;
	} dp_stat_t;

endpackage

// ----- rtl/ffa_slot_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_slot_pool
// Hands out free segment table slots: released slots from a stack first,
// then never-used slots from a fill counter.
// ----------------------------------------------------------------------------
module ffa_slot_pool (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      init,
	input  logic                      pop,
	input  logic                      push,
	input  logic [ffa_pkg::SEG_IW-1:0] push_idx,
	output logic [ffa_pkg::SEG_IW-1:0] slot_idx
);
	import ffa_pkg::*;

	logic [SEG_IW-1:0] stack_mem [MAX_SEGMENTS];
	logic [SEG_IW-1:0] top_s1;
	logic [SEG_PW-1:0] sp_q;
	logic [SEG_PW-1:0] fresh_q;
	logic [SEG_PW-1:0] sp_m1;

	assign sp_m1    = sp_q - SEG_PW'(1);
	assign slot_idx = (sp_q != '0) ? top_s1 : fresh_q[SEG_IW-1:0];

	// stack storage; top is read every cycle
	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[sp_q[SEG_IW-1:0]] <= push_idx;
		end
		top_s1 <= stack_mem[sp_m1[SEG_IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			fresh_q <= SEG_PW'(1);
		end else if (init) begin
			sp_q    <= '0;
			fresh_q <= SEG_PW'(1);
		end else if (push) begin
			sp_q <= sp_q + SEG_PW'(1);
		end else if (pop) begin
			if (sp_q != '0) begin
				sp_q <= sp_m1;
			end else begin
				fresh_q <= fresh_q + SEG_PW'(1);
			end
		end
	end

endmodule

// ----- rtl/ffa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_datapath
// Segment table, record table, counters and result register, driven by the
// controller's command each cycle.
// ----------------------------------------------------------------------------
module ffa_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ffa_pkg::cmd_t        cmd,
	output ffa_pkg::dp_stat_t    stat,
	input  logic [31:0]          cfg_data,
	input  logic [1:0]           op,
	input  logic [31:0]          alloc_size,
	input  logic [7:0]           record_id,
	input  logic [31:0]          record_offset,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic [1:0]           status,
	output logic [31:0]          granted_offset,
	output logic [7:0]           granted_id,
	output logic                 id_valid,
	output logic [3:0]           evictions_done,
	output logic [31:0]          bytes_used
);
	import ffa_pkg::*;

	seg_node_t seg_mem [MAX_SEGMENTS];
	rec_word_t rec_mem [MAX_RECORDS];
	seg_node_t seg_rd_s1;
	rec_word_t rec_rd_s1;

	logic [31:0]         pool_q;
	seg_node_t           head_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [LEN_W-1:0]    used_q;
	logic [REC_CW-1:0]   rec_count_q;
	logic [SEG_PW-1:0]   slots_q;
	logic [1:0]          op_q;
	logic [31:0]         size_q;
	logic [REC_IW-1:0]   id_q;
	logic [31:0]         want_q;
	logic [SEG_PW-1:0]   cur_q;
	seg_node_t           cur_node_q;
	logic [SEG_PW-1:0]   prev_q;
	seg_node_t           prev_node_q;
	logic [SEG_IW-1:0]   new_q;
	logic [31:0]         off_q;
	logic [3:0]          ev_q;
	logic [1:0]          st_q;
	logic [31:0]         goff_q;
	logic [REC_IW-1:0]   gid_q;
	logic                idv_q;
	logic [REC_CW-1:0]   scan_i_q;
	logic                pend_q;
	logic [REC_IW-1:0]   pend_idx_q;
	logic                best_v_q;
	logic [REC_IW-1:0]   best_idx_q;
	rec_word_t           best_word_q;
	logic                out_valid_q;
	logic [1:0]          out_status_q;
	logic [31:0]         out_goff_q;
	logic [7:0]          out_gid_q;
	logic                out_idv_q;
	logic [3:0]          out_ev_q;
	logic [31:0]         out_used_q;

	seg_node_t           node;
	logic [LEN_W-1:0]    size_ext;
	logic [SEG_IW-1:0]   seg_ra;
	logic [REC_IW-1:0]   rec_ra;
	logic                wr_en;
	logic [SEG_PW-1:0]   wr_idx;
	seg_node_t           wr_node;
	logic                rec_we;
	logic [REC_IW-1:0]   rec_wa;
	rec_word_t           rec_wd;
	logic                touch_hit;
	logic                prev_merge;
	logic                take_best;
	logic                pop;
	logic                push;
	logic [SEG_IW-1:0]   push_idx;
	logic [SEG_IW-1:0]   slot_idx;
	logic [LEN_W-1:0]    new_len;

	ffa_slot_pool u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (cmd == CMD_CFG),
		.pop      (pop),
		.push     (push),
		.push_idx (push_idx),
		.slot_idx (slot_idx)
	);

	// current node: list head lives in registers, the rest in the table
	assign node     = (cur_q == '0) ? head_q : seg_rd_s1;
	assign size_ext = {1'b0, size_q};

	assign stat.op         = op_q;
	assign stat.size_zero  = (size_q == '0);
	assign stat.node_fit   = node.free && (node.len >= size_ext);
	assign stat.node_exact = (node.len == size_ext);
	assign stat.node_end   = (node.next == SEG_END);
	assign stat.node_match = (node.start == off_q) && !node.free;
	assign stat.tfull      = (slots_q >= SEG_PW'(MAX_SEGMENTS));
	assign stat.ev_over    = (ev_q > 4'(EVICT_LIMIT));
	assign stat.scan_done  = !pend_q && (scan_i_q >= rec_count_q);
	assign stat.best_valid = best_v_q;
	assign stat.out_busy   = out_valid_q && out_stall;

	assign touch_hit  = ({1'b0, id_q} < rec_count_q) && (rec_rd_s1.start == want_q);
	assign prev_merge = (prev_q != SEG_END) && prev_node_q.free;
	assign take_best  = pend_q && rec_rd_s1.active &&
		(!best_v_q || (rec_rd_s1.frame < best_word_q.frame));
	assign new_len    = cur_node_q.len + seg_rd_s1.len;

	assign seg_ra = (cmd == CMD_NX_RD) ? cur_node_q.next[SEG_IW-1:0] : cur_q[SEG_IW-1:0];
	assign rec_ra = (cmd == CMD_SCAN) ? scan_i_q[REC_IW-1:0] : id_q;

	assign pop  = (cmd == CMD_SPLIT1);
	assign push = ((cmd == CMD_MERGE_NX) && seg_rd_s1.free) ||
		((cmd == CMD_MERGE_PREV) && prev_merge);
	assign push_idx = (cmd == CMD_MERGE_NX) ? cur_node_q.next[SEG_IW-1:0]
		: cur_q[SEG_IW-1:0];

	// segment write selection
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = cur_q;
		wr_node = node;
		case (cmd)
			CMD_SPLIT1: begin
				wr_en        = 1'b1;
				wr_idx       = {1'b0, slot_idx};
				wr_node.start = node.start + size_q;
				wr_node.len  = node.len - size_ext;
				wr_node.free = 1'b1;
				wr_node.next = node.next;
			end
			CMD_SPLIT2: begin
				wr_en        = 1'b1;
				wr_node      = cur_node_q;
				wr_node.len  = size_ext;
				wr_node.free = 1'b0;
				wr_node.next = {1'b0, new_q};
			end
			CMD_MARK_USED: begin
				wr_en        = 1'b1;
				wr_node.free = 1'b0;
			end
			CMD_MERGE_PREV: begin
				wr_en = 1'b1;
				if (prev_merge) begin
					wr_idx       = prev_q;
					wr_node      = prev_node_q;
					wr_node.len  = prev_node_q.len + cur_node_q.len;
					wr_node.next = cur_node_q.next;
				end else begin
					wr_node = cur_node_q;
				end
			end
			default: begin
			end
		endcase
	end

	// record write selection
	always_comb begin
		rec_we = 1'b0;
		rec_wa = id_q;
		rec_wd = '{start: goff_q, frame: frame_q, active: 1'b1};
		case (cmd)
			CMD_REC_NEW: begin
				rec_we = (rec_count_q < REC_CW'(MAX_RECORDS));
				rec_wa = rec_count_q[REC_IW-1:0];
			end
			CMD_TOUCH: begin
				rec_we = touch_hit;
				rec_wd = '{start: rec_rd_s1.start, frame: frame_q, active: rec_rd_s1.active};
			end
			CMD_EVICT: begin
				rec_we = 1'b1;
				rec_wa = best_idx_q;
				rec_wd = best_word_q;
				rec_wd.active = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx != '0)) begin
			seg_mem[wr_idx[SEG_IW-1:0]] <= wr_node;
		end
		seg_rd_s1 <= seg_mem[seg_ra];
		if (rec_we) begin
			rec_mem[rec_wa] <= rec_wd;
		end
		rec_rd_s1 <= rec_mem[rec_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				size_q <= alloc_size;
				id_q   <= record_id;
				want_q <= record_offset;
			end
			CMD_STEP: begin
				prev_node_q <= node;
			end
			CMD_SPLIT1: begin
				cur_node_q <= node;
				new_q      <= slot_idx;
			end
			CMD_FREE_HIT: begin
				cur_node_q <= '{start: node.start, len: node.len, free: 1'b1,
					next: node.next};
			end
			CMD_MERGE_NX: begin
				if (seg_rd_s1.free) begin
					cur_node_q.len  <= new_len;
					cur_node_q.next <= seg_rd_s1.next;
				end
			end
			CMD_EVICT: begin
				off_q <= best_word_q.start;
			end
			CMD_SCAN: begin
				if (take_best) begin
					best_idx_q  <= pend_idx_q;
					best_word_q <= rec_rd_s1;
				end
				pend_idx_q <= scan_i_q[REC_IW-1:0];
			end
			CMD_EMIT: begin
				out_status_q <= st_q;
				out_goff_q   <= goff_q;
				out_gid_q    <= 8'(gid_q);
				out_idv_q    <= idv_q;
				out_ev_q     <= ev_q;
				out_used_q   <= used_q[31:0];
			end
			default: begin
			end
		endcase
	end

	// control and bookkeeping registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= POOL_RESET;
			head_q      <= '{start: '0, len: {1'b0, POOL_RESET}, free: 1'b1, next: SEG_END};
			frame_q     <= '0;
			used_q      <= '0;
			rec_count_q <= '0;
			slots_q     <= SEG_PW'(1);
			op_q        <= OP_ALLOC;
			cur_q       <= '0;
			prev_q      <= SEG_END;
			ev_q        <= '0;
			st_q        <= ST_OK;
			goff_q      <= '0;
			gid_q       <= '0;
			idv_q       <= 1'b0;
			scan_i_q    <= '0;
			pend_q      <= 1'b0;
			best_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result word, or drop the current one once taken
			if (cmd == CMD_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en && (wr_idx == '0)) begin
				head_q <= wr_node;
			end
			case (cmd)
				CMD_CFG: begin
					pool_q      <= cfg_data;
					head_q      <= '{start: '0, len: {1'b0, cfg_data}, free: 1'b1,
						next: SEG_END};
					slots_q     <= SEG_PW'(1);
					rec_count_q <= '0;
					used_q      <= '0;
				end
				CMD_LOAD: begin
					op_q   <= op;
					st_q   <= ST_OK;
					goff_q <= '0;
					gid_q  <= '0;
					idv_q  <= 1'b0;
					ev_q   <= '0;
					cur_q  <= '0;
					prev_q <= SEG_END;
					if (op == OP_TICK) begin
						frame_q <= frame_q + FRAME_W'(1);
					end
				end
				CMD_SET_OOM:   st_q <= ST_OOM;
				CMD_SET_TFULL: st_q <= ST_TFULL;
				CMD_STEP: begin
					prev_q <= cur_q;
					cur_q  <= node.next;
				end
				CMD_MARK_USED: begin
					goff_q <= node.start;
					used_q <= used_q + size_ext;
				end
				CMD_SPLIT1: begin
					slots_q <= slots_q + SEG_PW'(1);
				end
				CMD_SPLIT2: begin
					goff_q <= cur_node_q.start;
					used_q <= used_q + size_ext;
				end
				CMD_REC_NEW: begin
					if (rec_count_q < REC_CW'(MAX_RECORDS)) begin
						gid_q       <= rec_count_q[REC_IW-1:0];
						idv_q       <= 1'b1;
						rec_count_q <= rec_count_q + REC_CW'(1);
					end
				end
				CMD_SCAN_INIT: begin
					scan_i_q <= '0;
					pend_q   <= 1'b0;
					best_v_q <= 1'b0;
				end
				CMD_SCAN: begin
					if (take_best) begin
						best_v_q <= 1'b1;
					end
					if (scan_i_q < rec_count_q) begin
						pend_q   <= 1'b1;
						scan_i_q <= scan_i_q + REC_CW'(1);
					end else begin
						pend_q <= 1'b0;
					end
				end
				CMD_EVICT: begin
					cur_q  <= '0;
					prev_q <= SEG_END;
					ev_q   <= ev_q + 4'd1;
				end
				CMD_FREE_HIT: begin
					used_q <= (used_q >= node.len) ? used_q - node.len : '0;
				end
				CMD_MERGE_NX: begin
					if (seg_rd_s1.free) begin
						slots_q <= slots_q - SEG_PW'(1);
					end
				end
				CMD_MERGE_PREV: begin
					if (prev_merge) begin
						slots_q <= slots_q - SEG_PW'(1);
					end
				end
				CMD_WALK_INIT: begin
					cur_q  <= '0;
					prev_q <= SEG_END;
				end
				CMD_TOUCH: begin
					if (!touch_hit) begin
						st_q <= ST_NOMATCH;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign granted_offset = out_goff_q;
	assign granted_id     = out_gid_q;
	assign id_valid       = out_idv_q;
	assign evictions_done = out_ev_q;
	assign bytes_used     = out_used_q;

	a_slots_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slots_q >= SEG_PW'(1)) && (slots_q <= SEG_PW'(MAX_SEGMENTS)))
		else $error("segment slot count out of range");

	a_ev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ev_q <= 4'(EVICT_LIMIT + 1))
		else $error("eviction count past limit");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= {1'b0, pool_q})
		else $error("bytes in use exceed pool");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd == CMD_EMIT))
		else $error("result shown without emit");

endmodule

// ----- rtl/ffa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate walk, LRU scan, coalescing free, touch and tick.
// ----------------------------------------------------------------------------
module ffa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  ffa_pkg::dp_stat_t stat,
	output ffa_pkg::cmd_t     cmd
);
	import ffa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_TOUCH,
		S_A_RD,
		S_A_EVAL,
		S_SPLIT2,
		S_REC,
		S_E_SCAN,
		S_F_RD,
		S_F_EVAL,
		S_F_NX_RD,
		S_F_NX,
		S_F_PREV,
		S_RESTART,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE) || cfg_valid;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					cmd = CMD_CFG;
				end else if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.op == OP_ALLOC) begin
					if (stat.size_zero) begin
						cmd     = CMD_SET_OOM;
						state_d = S_FINISH;
					end else begin
						state_d = S_A_RD;
					end
				end else if (stat.op == OP_TOUCH) begin
					state_d = S_TOUCH;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_TOUCH: begin
				cmd     = CMD_TOUCH;
				state_d = S_FINISH;
			end
			S_A_RD: state_d = S_A_EVAL;
			S_A_EVAL: begin
				if (stat.node_fit) begin
					if (stat.node_exact) begin
						cmd     = CMD_MARK_USED;
						state_d = S_REC;
					end else if (stat.tfull) begin
						cmd     = CMD_SET_TFULL;
						state_d = S_FINISH;
					end else begin
						cmd     = CMD_SPLIT1;
						state_d = S_SPLIT2;
					end
				end else if (stat.node_end) begin
					if (stat.ev_over) begin
						cmd     = CMD_SET_OOM;
						state_d = S_FINISH;
					end else begin
						cmd     = CMD_SCAN_INIT;
						state_d = S_E_SCAN;
					end
				end else begin
					cmd     = CMD_STEP;
					state_d = S_A_RD;
				end
			end
			S_SPLIT2: begin
				cmd     = CMD_SPLIT2;
				state_d = S_REC;
			end
			S_REC: begin
				cmd     = CMD_REC_NEW;
				state_d = S_FINISH;
			end
			S_E_SCAN: begin
				if (!stat.scan_done) begin
					cmd = CMD_SCAN;
				end else if (stat.best_valid) begin
					cmd     = CMD_EVICT;
					state_d = S_F_RD;
				end else begin
					cmd     = CMD_SET_OOM;
					state_d = S_FINISH;
				end
			end
			S_F_RD: state_d = S_F_EVAL;
			S_F_EVAL: begin
				if (stat.node_match) begin
					cmd     = CMD_FREE_HIT;
					state_d = stat.node_end ? S_F_PREV : S_F_NX_RD;
				end else if (stat.node_end) begin
					state_d = S_RESTART;
				end else begin
					cmd     = CMD_STEP;
					state_d = S_F_RD;
				end
			end
			S_F_NX_RD: begin
				cmd     = CMD_NX_RD;
				state_d = S_F_NX;
			end
			S_F_NX: begin
				cmd     = CMD_MERGE_NX;
				state_d = S_F_PREV;
			end
			S_F_PREV: begin
				cmd     = CMD_MERGE_PREV;
				state_d = S_RESTART;
			end
			S_RESTART: begin
				cmd     = CMD_WALK_INIT;
				state_d = S_A_RD;
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd     = CMD_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/first_fit_allocator_lru_evict.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_lru_evict
// Byte pool allocator: first-fit split, coalescing free, LRU record eviction.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (op, alloc_size, record_id, record_offset) are taken when
//   in_valid is high and in_stall is low. Each input word gives exactly one
//   result word (status, granted_offset, granted_id, id_valid,
//   evictions_done, bytes_used), taken when out_valid is high and out_stall
//   is low. The block works on one word at a time.
//   An allocate walks the segment list from the head (one table read
//   port); each eviction adds a record scan plus a second list walk to
//   the freed segment, and the allocate walk is then repeated.
//   The result sits in an output register; the next word is accepted while
//   it waits, and the block holds at the end of that word until the receiver
//   drops out_stall.
//   A write on the cfg channel (cfg_valid/cfg_ready, cfg_data) sets the pool
//   size and reinitializes the pool to one free segment, clears records and
//   bytes used; the frame count is kept. Write only while idle.
//   Reset: pool of 64 MiB as one free segment, no records, frame 0. There
//   is no clearing pass; tables are tracked by fill counters.
// ----------------------------------------------------------------------------
module first_fit_allocator_lru_evict (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] alloc_size,
	input  logic [7:0]  record_id,
	input  logic [31:0] record_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] granted_offset,
	output logic [7:0]  granted_id,
	output logic        id_valid,
	output logic [3:0]  evictions_done,
	output logic [31:0] bytes_used,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import ffa_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;

	// sequencer: decides one datapath command per cycle
	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// tables, counters and the result register
	ffa_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_data       (cfg_data),
		.op             (op),
		.alloc_size     (alloc_size),
		.record_id      (record_id),
		.record_offset  (record_offset),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.granted_offset (granted_offset),
		.granted_id     (granted_id),
		.id_valid       (id_valid),
		.evictions_done (evictions_done),
		.bytes_used     (bytes_used)
	);

endmodule
